>>> sv/max_pool_2x2_with_argmax_mask_top_assert.svh
// assertion macros for the 2x2 max pooling block
// no dependencies; included by the top level only
`ifndef MAX_POOL_2X2_WITH_ARGMAX_MASK_TOP_ASSERT_SVH
`define MAX_POOL_2X2_WITH_ARGMAX_MASK_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define MPOOL_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("mpool: invariant violated");

// antecedent implies consequent in the same cycle
`define MPOOL_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpool: implication violated");

// antecedent implies consequent in the next cycle
`define MPOOL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpool: next-cycle implication violated");

`endif

>>> sv/mpool_pkg.sv
// shared constants for the 2x2 max pooling block
// no dependencies
package mpool_pkg;

   localparam int MAX_SIDE_DEFAULT    = 64;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam int HALF_SIDE_BITS  = 6;
   localparam logic [HALF_SIDE_BITS-1:0] HALF_SIDE_RESET = 6'd12;

   // position mask bit positions
   localparam int MASK_BITS     = 4;
   localparam int POS_TOP_LEFT  = 0;
   localparam int POS_TOP_RIGHT = 1;
   localparam int POS_BOT_LEFT  = 2;
   localparam int POS_BOT_RIGHT = 3;

endpackage

>>> sv/max_pool_2x2_with_argmax_mask_top.sv
// 2x2 stride-2 max pooling with a mask of the positions holding the maximum
// depends on mpool_pkg and max_pool_2x2_with_argmax_mask_top_assert.svh
// Usage:
//   req_* : one feature map sample per item, row-major, map side 2*half_side.
//   rsp_* : one item per 2x2 window, emitted for the bottom-right sample;
//           pooled_value is the window maximum, position_mask flags every
//           sample equal to it (zero when all four are zero), last_window
//           marks the final window of the map, after which the counters wrap.
//   csr_* : writing half_side (0 reads as 1, above MAX_SIDE/2 clamps) restarts
//           the map at row 0, column 0. Write only while the block is idle.
// Throughput is one sample per cycle with no bubbles while the output does not
// stall. A result reaches rsp_valid through the compare stage, which is loaded
// along with the synchronous read of the line store, and then the output register.
// The line store is a single-port memory: even rows write it, odd rows read
// it, so each accepted sample uses the port exactly once.
// Reset clears the counters, the pipeline valids and sets half_side to 12;
// the line store is not cleared and is always written before it is read.
// When rsp_ready is low with a result waiting, a second finished window stalls
// in the compare stage and req_ready drops until the output register drains.
`include "max_pool_2x2_with_argmax_mask_top_assert.svh"

module max_pool_2x2_with_argmax_mask_top #(
   parameter int MAX_SIDE    = mpool_pkg::MAX_SIDE_DEFAULT,
   parameter int SAMPLE_BITS = mpool_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]           rsp_pooled_value,
   output logic [mpool_pkg::MASK_BITS-1:0]         rsp_position_mask,
   output logic                                    rsp_last_window,
   input  logic                                    csr_wr_en,
   input  logic [mpool_pkg::HALF_SIDE_BITS-1:0]    csr_wr_data
);

   localparam int CW       = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
   localparam int HALF_MAX = MAX_SIDE / 2;

   // configuration and position counters
   logic [mpool_pkg::HALF_SIDE_BITS-1:0] half_side_ff;
   logic [CW-1:0] row_ff, row_in, col_ff, col_in;
   logic [CW-1:0] half_m1, side_m1;

   // line store and its read data
   logic [SAMPLE_BITS-1:0] upper_row_store_ff [MAX_SIDE];
   logic [SAMPLE_BITS-1:0] rd_ff;
   logic                   mem_we, mem_re;

   // window assembly
   logic signed [SAMPLE_BITS-1:0] left_hold_ff;

   // compare stage
   logic                          s2_valid_ff, s2_valid_in;
   logic signed [SAMPLE_BITS-1:0] s2_tl_ff, s2_bl_ff, s2_br_ff;
   logic                          s2_last_ff;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]       rsp_value_ff;
   logic [mpool_pkg::MASK_BITS-1:0]     rsp_mask_ff;
   logic                                rsp_last_ff;

   logic accept, odd_row, odd_col, pair_done, stall, s2_stall, load_out;
   logic signed [SAMPLE_BITS-1:0] win_tr, max_a, max_b, win_max;
   logic [mpool_pkg::MASK_BITS-1:0] win_mask;

   // clamp the configured half side, then form side-1
   always_comb begin
      if (half_side_ff == '0) begin
         half_m1 = '0;
      end else if (int'(half_side_ff) > HALF_MAX) begin
         half_m1 = CW'(HALF_MAX - 1);
      end else begin
         half_m1 = CW'(half_side_ff - 1'b1);
      end
      side_m1 = CW'({half_m1, 1'b1});
   end

   assign stall     = rsp_valid_ff & ~rsp_ready;
   assign s2_stall  = s2_valid_ff & stall;
   assign req_ready = ~s2_stall;
   assign accept    = req_valid & req_ready;
   assign odd_row   = row_ff[0];
   assign odd_col   = col_ff[0];
   assign pair_done = accept & odd_row & odd_col;

   // even rows fill the store, odd rows read the upper samples back
   assign mem_we = accept & ~odd_row;
   assign mem_re = accept & odd_row;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (csr_wr_en) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (col_ff == side_m1) begin
            col_in = '0;
            row_in = (row_ff == side_m1) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign s2_valid_in  = pair_done | s2_stall;
   assign load_out     = s2_valid_ff & ~stall;
   assign rsp_valid_in = s2_valid_ff | stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_side_ff <= mpool_pkg::HALF_SIDE_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            half_side_ff <= csr_wr_data;
         end
         row_ff       <= row_in;
         col_ff       <= col_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // single-port line store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         upper_row_store_ff[col_ff] <= req_sample;
      end
      if (mem_re) begin
         rd_ff <= upper_row_store_ff[col_ff];
      end
   end

   // rd_ff holds top-left from the even-column read until the odd column arrives
   always_ff @(posedge clock) begin
      if (accept & odd_row & ~odd_col) begin
         left_hold_ff <= req_sample;
      end
      if (pair_done) begin
         s2_tl_ff   <= $signed(rd_ff);
         s2_bl_ff   <= left_hold_ff;
         s2_br_ff   <= req_sample;
         s2_last_ff <= (row_ff == side_m1) && (col_ff == side_m1);
      end
   end

   // top-right arrives from the odd-column read
   assign win_tr  = $signed(rd_ff);
   assign max_a   = (win_tr > s2_tl_ff) ? win_tr : s2_tl_ff;
   assign max_b   = (s2_bl_ff > max_a) ? s2_bl_ff : max_a;
   assign win_max = (s2_br_ff > max_b) ? s2_br_ff : max_b;

   always_comb begin
      win_mask = '0;
      if (!(s2_tl_ff == 0 && win_tr == 0 && s2_bl_ff == 0 && s2_br_ff == 0)) begin
         win_mask[mpool_pkg::POS_TOP_LEFT]  = (s2_tl_ff == win_max);
         win_mask[mpool_pkg::POS_TOP_RIGHT] = (win_tr == win_max);
         win_mask[mpool_pkg::POS_BOT_LEFT]  = (s2_bl_ff == win_max);
         win_mask[mpool_pkg::POS_BOT_RIGHT] = (s2_br_ff == win_max);
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_value_ff <= win_max;
         rsp_mask_ff  <= win_mask;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pooled_value  = rsp_value_ff;
   assign rsp_position_mask = rsp_mask_ff;
   assign rsp_last_window   = rsp_last_ff;

   // assertions
   `MPOOL_ASSERT_ALWAYS(a_counters_ok, clock, reset, (row_ff <= side_m1) && (col_ff <= side_m1))
   `MPOOL_ASSERT_IMPL(a_zero_mask, clock, reset, rsp_valid_ff && ~|rsp_mask_ff, ~|rsp_value_ff)
   `MPOOL_ASSERT_NEXT(a_pair_enters_compare, clock, reset, pair_done, s2_valid_ff)
   `MPOOL_ASSERT_NEXT(a_s2_held, clock, reset, s2_stall, s2_valid_ff && $stable(s2_br_ff))
   `MPOOL_ASSERT_NEXT(a_rd_held, clock, reset, s2_stall, $stable(rd_ff))

endmodule

>>> test/pool_result_check.sv
// checker for the 2x2 max pooling block: watches both channels and the csr port,
// predicts every window result and compares it field by field; needs mpool_pkg
module pool_result_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [mpool_pkg::SAMPLE_BITS_DEFAULT-1:0] req_sample,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [mpool_pkg::SAMPLE_BITS_DEFAULT-1:0] rsp_pooled_value,
   input  logic [mpool_pkg::MASK_BITS-1:0]      rsp_position_mask,
   input  logic                                 rsp_last_window,
   input  logic                                 csr_wr_en,
   input  logic [mpool_pkg::HALF_SIDE_BITS-1:0] csr_wr_data,
   output int                                   fail_count,
   output int                                   windows_seen,
   output int                                   maps_seen,
   output int                                   windows_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB   = mpool_pkg::SAMPLE_BITS_DEFAULT;
   localparam int MAXS = mpool_pkg::MAX_SIDE_DEFAULT;

   typedef struct packed {
      logic [SB-1:0]                   value;
      logic [mpool_pkg::MASK_BITS-1:0] mask;
      logic                            last;
   } window_type;

   logic signed [SB-1:0]                line_store [MAXS];
   logic signed [SB-1:0]                left_hold;
   logic [mpool_pkg::HALF_SIDE_BITS-1:0] half_side;
   int                                  row;
   int                                  col;
   window_type                          expected_windows [$];

   // 0 reads as 1, anything whose side would pass the store depth clamps
   function automatic int side_of(input logic [mpool_pkg::HALF_SIDE_BITS-1:0] h);
      if (h == 0) return 2;
      if (h > MAXS / 2) return MAXS;
      return 2 * h;
   endfunction

   task automatic absorb_sample(input logic signed [SB-1:0] s);
      int                              side;
      logic signed [SB-1:0]            tl;
      logic signed [SB-1:0]            tr;
      logic signed [SB-1:0]            mx;
      logic [mpool_pkg::MASK_BITS-1:0] m;
      window_type                      w;
      side = side_of(half_side);
      if (row >= side || col >= side) begin
         row = 0;
         col = 0;
      end
      if (row % 2 == 0) begin
         line_store[col] = s;
      end else if (col % 2 == 0) begin
         left_hold = s;
      end else begin
         tl = line_store[col - 1];
         tr = line_store[col];
         mx = tl;
         if (tr > mx) mx = tr;
         if (left_hold > mx) mx = left_hold;
         if (s > mx) mx = s;
         m = '0;
         // an all-zero window flags nothing
         if (!(tl == 0 && tr == 0 && left_hold == 0 && s == 0)) begin
            m[mpool_pkg::POS_TOP_LEFT]  = (tl == mx);
            m[mpool_pkg::POS_TOP_RIGHT] = (tr == mx);
            m[mpool_pkg::POS_BOT_LEFT]  = (left_hold == mx);
            m[mpool_pkg::POS_BOT_RIGHT] = (s == mx);
         end
         w.value = mx;
         w.mask  = m;
         w.last  = (row == side - 1) && (col == side - 1);
         expected_windows.insert(expected_windows.size(), w);
      end
      col++;
      if (col >= side) begin
         col = 0;
         row++;
         if (row >= side) row = 0;
      end
   endtask

   initial begin
      fail_count   = 0;
      windows_seen = 0;
      maps_seen    = 0;
      windows_owed = 0;
   end

   always @(posedge clock) begin
      window_type w;
      if (reset) begin
         foreach (line_store[i]) line_store[i] = '0;
         left_hold = '0;
         half_side = mpool_pkg::HALF_SIDE_RESET;
         row = 0;
         col = 0;
         expected_windows.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_windows.size() == 0) begin
               $display("%0t: unexpected result item pooled_value %0d mask %b last %b",
                        $time, $signed(rsp_pooled_value), rsp_position_mask,
                        rsp_last_window);
               fail_count++;
            end else begin
               w = expected_windows.pop_front();
               if (rsp_pooled_value !== w.value) begin
                  $display("%0t: window %0d pooled_value expected %0d got %0d", $time,
                           windows_seen, $signed(w.value), $signed(rsp_pooled_value));
                  fail_count++;
               end
               if (rsp_position_mask !== w.mask) begin
                  $display("%0t: window %0d position_mask expected %b got %b", $time,
                           windows_seen, w.mask, rsp_position_mask);
                  fail_count++;
               end
               if (rsp_last_window !== w.last) begin
                  $display("%0t: window %0d last_window expected %b got %b", $time,
                           windows_seen, w.last, rsp_last_window);
                  fail_count++;
               end
            end
            windows_seen++;
            if (rsp_last_window === 1'b1) maps_seen++;
         end
         // a write restarts the map
         if (csr_wr_en) begin
            half_side = csr_wr_data;
            row = 0;
            col = 0;
         end
         if (req_valid && req_ready) absorb_sample(req_sample);
      end
      windows_owed = expected_windows.size();
   end

endmodule

>>> test/testbench.sv
// top of the 2x2 max pooling testbench: clock, reset, sample and ready stimulus,
// csr writes and the verdict; depends on mpool_pkg, pool_result_check and the block
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB = mpool_pkg::SAMPLE_BITS_DEFAULT;
   localparam int HB = mpool_pkg::HALF_SIDE_BITS;
   localparam int TARGET_SAMPLES = 1400;

   // corner windows on a 2x2 map, in arrival order top-left, top-right,
   // bottom-left, bottom-right
   localparam logic [SB-1:0] CORNER_WINDOWS [24] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h8000, 16'h8000, 16'h8000, 16'h8000,
      16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000,
      16'hFFFB, 16'h0064, 16'hFFFB, 16'h0063,
      16'h0001, 16'hFFFF, 16'h0000, 16'h0002,
      16'h0000, 16'h0000, 16'h0000, 16'hFFFF
   };

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [SB-1:0]                        req_sample = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [SB-1:0]                        rsp_pooled_value;
   logic [mpool_pkg::MASK_BITS-1:0]      rsp_position_mask;
   logic                                 rsp_last_window;
   logic                                 csr_wr_en = 1'b0;
   logic [mpool_pkg::HALF_SIDE_BITS-1:0] csr_wr_data = '0;

   int fail_count;
   int windows_seen;
   int maps_seen;
   int windows_owed;
   int samples_sent = 0;
   int settings_run = 0;
   bit steady = 1'b0;

   always #2 clock = ~clock;

   max_pool_2x2_with_argmax_mask_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pooled_value  (rsp_pooled_value),
      .rsp_position_mask (rsp_position_mask),
      .rsp_last_window   (rsp_last_window),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   pool_result_check check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pooled_value  (rsp_pooled_value),
      .rsp_position_mask (rsp_position_mask),
      .rsp_last_window   (rsp_last_window),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fail_count        (fail_count),
      .windows_seen      (windows_seen),
      .maps_seen         (maps_seen),
      .windows_owed      (windows_owed)
   );

   function automatic int idle_gap();
      return steady ? 0 : $urandom_range(0, 11);
   endfunction

   // small values make ties and all-zero windows common
   function automatic logic [SB-1:0] draw_sample();
      logic [SB-1:0] v;
      case ($urandom_range(0, 5))
         0: v = SB'($signed($urandom_range(0, 2)) - 1);
         1: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         2: v = SB'($urandom_range(0, 3));
         default: v = SB'($urandom());
      endcase
      return v;
   endfunction

   task automatic send_sample(input logic [SB-1:0] value);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      samples_sent++;
   endtask

   // hold off until every window is out, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (windows_owed != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_half_side(input logic [mpool_pkg::HALF_SIDE_BITS-1:0] h);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= h;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      settings_run++;
   endtask

   // receiver: random stall before taking each result item
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = idle_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int                                   phase;
      int                                   side;
      int                                   count;
      logic [mpool_pkg::HALF_SIDE_BITS-1:0] hs;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // two rows at the reset setting
      repeat (48) send_sample(draw_sample());

      set_half_side('0);
      foreach (CORNER_WINDOWS[i]) send_sample(CORNER_WINDOWS[i]);

      phase = 0;
      while (samples_sent < TARGET_SAMPLES) begin
         steady = ($urandom_range(0, 3) == 0);
         case (phase)
            0: hs = 6'd1;
            1: hs = 6'd32;
            2: hs = 6'd63;
            default: hs = ($urandom_range(0, 7) == 0) ? HB'($urandom_range(9, 63))
                                                       : HB'($urandom_range(0, 4));
         endcase
         set_half_side(hs);
         side = (hs == 0) ? 2 : (hs > 32) ? 64 : 2 * hs;
         // big maps get one or two row pairs only; small ones whole maps and sometimes a broken tail
         if (side >= 18) begin
            count = 2 * side * $urandom_range(1, 2);
         end else begin
            count = side * side * $urandom_range(1, 3);
            if ($urandom_range(0, 2) == 0) count += $urandom_range(1, side * side - 1);
         end
         repeat (count) send_sample(draw_sample());
         phase++;
      end

      steady = 1'b0;
      drain();
      $display("covered %0d samples over %0d half_side settings including 0 and 63",
               samples_sent, settings_run);
      $display("checked %0d windows, %0d of them closing a map", windows_seen, maps_seen);
      if (fail_count == 0 && windows_owed == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
